// File: hw/rtl/cdo_pkg.sv
// Shared constants and helpers for the calendar date offset block.
// Action codes, month table and leap rule on the year residue mod 400.
// No dependencies.
`default_nettype none

package cdo_pkg;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_SHIFT   = 2'd1;
  localparam logic [1:0] ACT_PREVIEW = 2'd2;
  localparam logic [1:0] ACT_COMPARE = 2'd3;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_DEC = 4'd12;

  // year mod 400 is split as ((year >> 4) mod 25) * 16 + year[3:0]
  localparam int          XW        = 16;
  localparam int          MUL_SHIFT = 20;
  localparam int          QW        = 2 * XW - MUL_SHIFT;
  localparam logic [15:0] MUL25     = 16'd41943;   // floor(2^20 / 25)
  localparam logic [15:0] DIV25     = 16'd25;

  typedef logic [8:0] ymod_t;

  localparam ymod_t MOD_LAST = 9'd399;

  function automatic logic is_leap(input ymod_t r);
    return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd0;
    if (m inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
      len = 5'd31;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else if (m == MON_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cdo_front.sv
// Front end: takes request beats, reduces the year mod 400 and checks loads.
// Emits one packed item per request into the queue. Depends on cdo_pkg.
`default_nettype none

module cdo_front #(
  parameter int YEAR_BITS   = 14,
  parameter int OFFSET_BITS = 21,
  parameter int ITEM_W      = YEAR_BITS + OFFSET_BITS + 21
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   req_valid,
  output logic                        req_stall,
  input  wire logic [1:0]             action,
  input  wire logic [YEAR_BITS-1:0]   in_year,
  input  wire logic [3:0]             in_month,
  input  wire logic [4:0]             in_day,
  input  wire logic [OFFSET_BITS-1:0] day_offset,
  input  wire logic                   q_full,
  output logic                        push,
  output logic [ITEM_W-1:0]           item
);
  import cdo_pkg::*;

  logic                   hold_valid;
  logic [1:0]             h_act;
  logic [YEAR_BITS-1:0]   h_year;
  logic [3:0]             h_month;
  logic [4:0]             h_day;
  logic [OFFSET_BITS-1:0] h_off;
  logic [2*XW-1:0]        h_prod;

  logic          accept;
  logic [XW-1:0] x_in;
  logic [XW-1:0] x_hold;
  logic [QW-1:0] quo;
  logic [XW-1:0] q25;
  logic [XW-1:0] rem;
  logic [XW-1:0] rem_fix;
  ymod_t         ymod;
  logic          load_ok;

  assign push      = hold_valid & ~q_full;
  assign req_stall = hold_valid & q_full;
  assign accept    = req_valid & ~req_stall;

  assign x_in = XW'(in_year >> 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
    if (accept) begin
      h_act   <= action;
      h_year  <= in_year;
      h_month <= in_month;
      h_day   <= in_day;
      h_off   <= day_offset;
      h_prod  <= (2*XW)'(x_in) * (2*XW)'(MUL25);
    end
  end

  // quotient may be one short; a single correction fixes the remainder
  assign x_hold  = XW'(h_year >> 4);
  assign quo     = h_prod[2*XW-1:MUL_SHIFT];
  assign q25     = XW'(quo) * DIV25;
  assign rem     = x_hold - q25;
  assign rem_fix = (rem >= DIV25) ? (rem - DIV25) : rem;
  assign ymod    = {rem_fix[4:0], h_year[3:0]};

  assign load_ok = (h_month inside {[4'd1:4'd12]}) && (h_day != 5'd0) &&
                   (h_day <= month_len(h_month, is_leap(ymod)));

  assign item = {h_act, h_year, h_month, h_day, ymod, h_off, load_ok};

endmodule

`default_nettype wire

// File: hw/rtl/cdo_queue.sv
// Two-entry queue between front and back end.
// Generic payload width. No dependencies.
`default_nettype none

module cdo_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic              not_empty,
  output logic [W-1:0]      rdata
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cdo_back.sv
// Back end: holds the stored date, executes load, compare and the month walk.
// Drives the registered response beat. Depends on cdo_pkg.
`default_nettype none

module cdo_back #(
  parameter int YEAR_BITS   = 14,
  parameter int OFFSET_BITS = 21,
  parameter int ITEM_W      = YEAR_BITS + OFFSET_BITS + 21
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire logic [ITEM_W-1:0]    q_item,
  output logic                      pop,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output logic [YEAR_BITS-1:0]      out_year,
  output logic [3:0]                out_month,
  output logic [4:0]                out_day,
  output logic                      error,
  output logic                      is_greater,
  output logic                      is_equal
);
  import cdo_pkg::*;

  localparam int DW = OFFSET_BITS + 2;
  localparam logic [YEAR_BITS-1:0] YMAX = {YEAR_BITS{1'b1}};
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic [1:0]             i_act;
  logic [YEAR_BITS-1:0]   i_year;
  logic [3:0]             i_month;
  logic [4:0]             i_day;
  ymod_t                  i_ymod;
  logic [OFFSET_BITS-1:0] i_off;
  logic                   i_ok;

  logic                 state;
  logic [YEAR_BITS-1:0] sy;
  logic [3:0]           sm;
  logic [4:0]           sd;
  ymod_t                symod;

  logic [YEAR_BITS-1:0] wy;
  logic [3:0]           wm;
  ymod_t                wymod;
  logic signed [DW-1:0] wd;
  logic                 fail;
  logic                 w_store;

  logic                 slot_free;
  logic                 walk_done;
  logic                 rsp_load;
  logic signed [DW-1:0] d_init;
  logic [4:0]           len_cur;
  logic [4:0]           len_prev;
  logic                 wrap_back;
  logic [3:0]           pm;
  ymod_t                pymod;
  logic                 fwd;
  logic                 bwd;
  logic [YEAR_BITS-1:0] y_next;
  logic [3:0]           m_next;
  ymod_t                ymod_next;
  logic signed [DW-1:0] d_next;
  logic                 fail_next;

  assign {i_act, i_year, i_month, i_day, i_ymod, i_off, i_ok} = q_item;

  assign slot_free = ~rsp_valid | ~rsp_stall;
  assign pop       = (state == ST_IDLE) & q_valid & slot_free;

  assign walk_done = (state == ST_WALK) & (fail | (~fwd & ~bwd));
  assign rsp_load  = (pop & (i_act inside {ACT_LOAD, ACT_COMPARE})) |
                     (walk_done & slot_free);

  assign d_init = $signed({{(DW-5){1'b0}}, sd}) +
                  $signed({{2{i_off[OFFSET_BITS-1]}}, i_off});

  assign wrap_back = (wm == MON_JAN);
  assign pm        = wrap_back ? MON_DEC : (wm - 4'd1);
  assign pymod     = (wymod == '0) ? MOD_LAST : (wymod - 9'd1);
  assign len_cur   = month_len(wm, is_leap(wymod));
  assign len_prev  = month_len(pm, is_leap(wrap_back ? pymod : wymod));
  assign fwd       = wd > $signed({{(DW-5){1'b0}}, len_cur});
  assign bwd       = wd[DW-1] | (wd == '0);

  always_comb begin
    y_next    = wy;
    m_next    = wm;
    ymod_next = wymod;
    d_next    = wd;
    fail_next = 1'b0;
    if (fwd) begin
      d_next = wd - $signed({{(DW-5){1'b0}}, len_cur});
      if (wm == MON_DEC) begin
        if (wy == YMAX) begin
          fail_next = 1'b1;
        end else begin
          m_next    = MON_JAN;
          y_next    = wy + YEAR_BITS'(1);
          ymod_next = (wymod == MOD_LAST) ? '0 : (wymod + 9'd1);
        end
      end else begin
        m_next = wm + 4'd1;
      end
    end else if (bwd) begin
      if (wrap_back && (wy == '0)) begin
        fail_next = 1'b1;
      end else begin
        m_next    = pm;
        y_next    = wrap_back ? (wy - YEAR_BITS'(1)) : wy;
        ymod_next = wrap_back ? pymod : wymod;
        d_next    = wd + $signed({{(DW-5){1'b0}}, len_prev});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      sy        <= '0;
      sm        <= MON_JAN;
      sd        <= 5'd1;
      symod     <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            if (i_act == ACT_LOAD) begin
              is_greater <= 1'b0;
              is_equal   <= 1'b0;
              if (i_ok) begin
                sy        <= i_year;
                sm        <= i_month;
                sd        <= i_day;
                symod     <= i_ymod;
                out_year  <= i_year;
                out_month <= i_month;
                out_day   <= i_day;
                error     <= 1'b0;
              end else begin
                out_year  <= sy;
                out_month <= sm;
                out_day   <= sd;
                error     <= 1'b1;
              end
            end else if (i_act == ACT_COMPARE) begin
              out_year   <= sy;
              out_month  <= sm;
              out_day    <= sd;
              error      <= 1'b0;
              is_greater <= {sy, sm, sd} > {i_year, i_month, i_day};
              is_equal   <= {sy, sm, sd} == {i_year, i_month, i_day};
            end else begin
              wy      <= sy;
              wm      <= sm;
              wymod   <= symod;
              wd      <= d_init;
              fail    <= 1'b0;
              w_store <= (i_act == ACT_SHIFT);
              state   <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (fail || (!fwd && !bwd)) begin
            if (slot_free) begin
              error      <= fail;
              is_greater <= 1'b0;
              is_equal   <= 1'b0;
              if (fail) begin
                out_year  <= sy;
                out_month <= sm;
                out_day   <= sd;
              end else begin
                out_year  <= wy;
                out_month <= wm;
                out_day   <= wd[4:0];
                if (w_store) begin
                  sy    <= wy;
                  sm    <= wm;
                  sd    <= wd[4:0];
                  symod <= wymod;
                end
              end
              state <= ST_IDLE;
            end
          end else begin
            wy    <= y_next;
            wm    <= m_next;
            wymod <= ymod_next;
            wd    <= d_next;
            fail  <= fail_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/calendar_date_day_offset_top.sv
// Calendar date register with signed day offset: top level.
// Ties front end, item queue and back end together. Depends on cdo_pkg.
//
// Request channel (req_valid/req_stall) carries action, in_year, in_month,
// in_day and day_offset; response channel (rsp_valid/rsp_stall) returns one
// beat per request with out_year, out_month, out_day, error, is_greater and
// is_equal, in request order.
// Front end registers a beat, reduces the year mod 400 and checks loads in the
// next cycle, then drops the item into a two-entry queue.
// Back end executes one item at a time. With nothing ahead, a load or compare
// passes the front-end hold register and the queue, then raises rsp_valid from
// the response register. Shift and preview walk one month per cycle, one step
// per month boundary crossed, and the back end takes no new item until the walk
// ends. Front accepts one beat per cycle while the queue has room.
// A stalled response holds in its output register; the back end then waits,
// the queue fills and req_stall rises.
// Reset clears the queue and response valid and sets the stored date to
// year 0, January 1.
`default_nettype none

module calendar_date_day_offset_top #(
  parameter int YEAR_BITS   = 14,
  parameter int OFFSET_BITS = 21
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   req_valid,
  output logic                        req_stall,
  input  wire logic [1:0]             action,
  input  wire logic [YEAR_BITS-1:0]   in_year,
  input  wire logic [3:0]             in_month,
  input  wire logic [4:0]             in_day,
  input  wire logic [OFFSET_BITS-1:0] day_offset,
  output logic                        rsp_valid,
  input  wire logic                   rsp_stall,
  output logic [YEAR_BITS-1:0]        out_year,
  output logic [3:0]                  out_month,
  output logic [4:0]                  out_day,
  output logic                        error,
  output logic                        is_greater,
  output logic                        is_equal
);

  localparam int ITEM_W = YEAR_BITS + OFFSET_BITS + 21;

  logic              push;
  logic              q_full;
  logic              q_valid;
  logic              pop;
  logic [ITEM_W-1:0] f_item;
  logic [ITEM_W-1:0] q_item;

  cdo_front #(
    .YEAR_BITS   (YEAR_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .ITEM_W      (ITEM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .action     (action),
    .in_year    (in_year),
    .in_month   (in_month),
    .in_day     (in_day),
    .day_offset (day_offset),
    .q_full     (q_full),
    .push       (push),
    .item       (f_item)
  );

  cdo_queue #(
    .W (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (f_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .rdata     (q_item)
  );

  cdo_back #(
    .YEAR_BITS   (YEAR_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .ITEM_W      (ITEM_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .out_year   (out_year),
    .out_month  (out_month),
    .out_day    (out_day),
    .error      (error),
    .is_greater (is_greater),
    .is_equal   (is_equal)
  );

endmodule

`default_nettype wire
